FILE: rtl/core/mse_pkg.sv
// shared types and constants for the mips subset execute stage
`timescale 1ns / 1ps
package mse_pkg;
  localparam int unsigned MemWords = 1024;
  localparam int unsigned MemAw = $clog2(MemWords);
  localparam logic [31:0] LinkOffset = 32'h8;
  localparam logic [4:0] LinkReg = 5'd31;

  typedef enum logic [4:0] {
    CmdMove = 5'd0, CmdAdd = 5'd1, CmdSub = 5'd2, CmdSubu = 5'd3, CmdMult = 5'd4,
    CmdMultu = 5'd5, CmdDiv = 5'd6, CmdDivu = 5'd7, CmdAnd = 5'd8, CmdNor = 5'd9,
    CmdOr = 5'd10, CmdSlt = 5'd11, CmdSltu = 5'd12, CmdSll = 5'd13, CmdSrl = 5'd14,
    CmdJr = 5'd15, CmdLi = 5'd16, CmdLw = 5'd17, CmdSw = 5'd18, CmdAddi = 5'd19,
    CmdAddiu = 5'd20, CmdAndi = 5'd21, CmdOri = 5'd22, CmdBeq = 5'd23, CmdBne = 5'd24,
    CmdJ = 5'd25, CmdJal = 5'd26, CmdMemload = 5'd27
  } cmd_e;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic        is_signed;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;
endpackage

FILE: rtl/core/mse_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module mse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/core/mse_div.sv
// radix-2 restoring divider, one quotient bit a cycle
`timescale 1ns / 1ps
module mse_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mse_pkg::div_req_t   req_i,
  output mse_pkg::div_rsp_t   rsp_o
);
  import mse_pkg::*;
  logic        busy_q, busy_d, neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [32:0] trial;
  logic        na, nb;

  always_comb begin
    na = req_i.is_signed & req_i.dividend[31];
    nb = req_i.is_signed & req_i.divisor[31];
    busy_d = busy_q; neg_d = neg_q; cnt_d = cnt_q;
    rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q;
    trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};
    rsp_o.done = 1'b0;
    rsp_o.quotient = neg_q ? (32'd0 - quo_q) : quo_q;
    if (req_i.start) begin
      busy_d = 1'b1; cnt_d = 6'd0; rem_d = '0; neg_d = na ^ nb;
      quo_d = na ? (32'd0 - req_i.dividend) : req_i.dividend;
      dvs_d = nb ? (32'd0 - req_i.divisor) : req_i.divisor;
    end else if (busy_q) begin
      if (cnt_q == 6'd32) begin
        busy_d = 1'b0;
        rsp_o.done = 1'b1;
      end else begin
        cnt_d = cnt_q + 6'd1;
        if (!trial[32]) rem_d = trial[31:0];
        else rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], ~trial[32]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    neg_q <= neg_d; rem_q <= rem_d; quo_q <= quo_d; dvs_q <= dvs_d;
  end
endmodule

FILE: rtl/core/mips_subset_execute_stage.sv
// top level: execute stage with register file and data memory
// One instruction at a time. Each passes through the states read (operand read from the register
// file ram), execute and result; lw and mult add a wait state for the data memory read or the
// registered product, and div and divu with a nonzero divisor wait in a divide state for the
// bit-serial divider. The next request is taken the cycle after the result is accepted. The
// register file has valid bits so it reads as zero after reset; writes land before the next
// request is taken.
`timescale 1ns / 1ps
module mips_subset_execute_stage (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  command_i,
  input  logic [4:0]  src_reg_s_i,
  input  logic [4:0]  src_reg_t_i,
  input  logic [4:0]  dst_reg_d_i,
  input  logic [4:0]  shift_amount_i,
  input  logic [15:0] immediate_i,
  input  logic [31:0] jump_target_i,
  input  logic [31:0] current_pc_i,
  input  logic [31:0] previous_pc_i,
  input  logic [9:0]  mem_word_index_i,
  input  logic [31:0] mem_word_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        reg_written_o,
  output logic [4:0]  written_reg_o,
  output logic [31:0] written_value_o,
  output logic        pc_changed_o,
  output logic [31:0] next_pc_o,
  output logic [31:0] next_previous_pc_o,
  output logic        divide_by_zero_o
);
  import mse_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StExec = 3'd2;
  localparam logic [2:0] StWait = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]  st_q, st_d;
  logic [31:0] rf_vld_q;
  logic        out_valid_q;
  // captured request
  logic [4:0]  cmd_q, rs_q, rt_q, rd_q, sh_q;
  logic [15:0] imm_q;
  logic [31:0] tgt_q, cpc_q, ppc_q, mdata_q;
  logic [MemAw-1:0] midx_q;
  // result
  logic        wr_q, jmp_q, dz_q;
  logic [4:0]  wreg_q;
  logic [31:0] wval_q, npc_q;
  logic        wr_d, jmp_d, dz_d;
  logic [4:0]  wreg_d;
  logic [31:0] wval_d, npc_d;
  logic [31:0] prod_q;

  logic        accept;
  logic [4:0]  rf_raddr_a, rf_raddr_b;
  logic [31:0] rdata_a, rdata_b, rf_a, rf_b, dm_rdata, se, sum_se;
  logic        rf_we, dm_we;
  logic [31:0] rf_wdata;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != StIdle) || out_valid_q;

  // keep reading the captured operands once the request is taken
  assign rf_raddr_a = (st_q == StIdle) ? src_reg_s_i : rs_q;
  assign rf_raddr_b = (st_q == StIdle) ? src_reg_t_i : rt_q;

  mse_ram #(.Width(32), .Depth(32)) u_rf_a (
    .clk_i, .we_i(rf_we), .waddr_i(wreg_q), .wdata_i(rf_wdata),
    .raddr_i(rf_raddr_a), .rdata_o(rdata_a));
  mse_ram #(.Width(32), .Depth(32)) u_rf_b (
    .clk_i, .we_i(rf_we), .waddr_i(wreg_q), .wdata_i(rf_wdata),
    .raddr_i(rf_raddr_b), .rdata_o(rdata_b));

  assign rf_a = rf_vld_q[rs_q] ? rdata_a : 32'd0;
  assign rf_b = rf_vld_q[rt_q] ? rdata_b : 32'd0;
  assign se = {{16{imm_q[15]}}, imm_q};
  assign sum_se = rf_a + se;

  assign dm_we = (st_q == StExec) && (cmd_q == CmdMemload);
  mse_ram #(.Width(32), .Depth(MemWords)) u_dmem (
    .clk_i, .we_i(dm_we), .waddr_i(midx_q), .wdata_i(mdata_q),
    .raddr_i(sum_se[MemAw-1:0]), .rdata_o(dm_rdata));

  mse_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  always_comb begin
    div_req.start = (st_q == StExec) && (cmd_q == CmdDiv || cmd_q == CmdDivu) && (rf_b != 0);
    div_req.is_signed = (cmd_q == CmdDiv);
    div_req.dividend = rf_a;
    div_req.divisor = rf_b;
  end

  // write back once the result is final
  assign rf_we = (st_q == StOut) && wr_q;
  assign rf_wdata = wval_q;

  always_comb begin
    st_d = st_q;
    wr_d = wr_q; jmp_d = jmp_q; dz_d = dz_q; wreg_d = wreg_q; wval_d = wval_q; npc_d = npc_q;
    case (st_q)
      StIdle: if (accept) st_d = StRead;
      StRead: st_d = StExec;
      StExec: begin
        wr_d = 1'b1; wreg_d = rd_q; wval_d = 32'd0; jmp_d = 1'b0; dz_d = 1'b0;
        npc_d = cpc_q; st_d = StOut;
        case (cmd_q)
          CmdMove: wval_d = rf_a;
          CmdAdd: wval_d = rf_a + rf_b;
          CmdSub, CmdSubu: wval_d = rf_a - rf_b;
          CmdMult, CmdMultu: st_d = StWait;
          CmdDiv, CmdDivu: begin
            if (rf_b == 32'd0) dz_d = 1'b1;
            else st_d = StDiv;
          end
          CmdAnd: wval_d = rf_a & rf_b;
          CmdNor: wval_d = ~(rf_a | rf_b);
          CmdOr: wval_d = rf_a | rf_b;
          CmdSlt: wval_d = {31'd0, $signed(rf_a) < $signed(rf_b)};
          CmdSltu: wval_d = {31'd0, rf_a < rf_b};
          CmdSll: wval_d = rf_b << sh_q;
          CmdSrl: wval_d = rf_b >> sh_q;
          CmdJr: begin wr_d = 1'b0; jmp_d = 1'b1; npc_d = rf_a; end
          CmdLi: begin wreg_d = rt_q; wval_d = {16'd0, imm_q}; end
          CmdLw: begin wreg_d = rt_q; st_d = StWait; end
          CmdAddi, CmdAddiu: begin wreg_d = rt_q; wval_d = sum_se; end
          CmdAndi: begin wreg_d = rt_q; wval_d = rf_a & {16'd0, imm_q}; end
          CmdOri: begin wreg_d = rt_q; wval_d = rf_a | {16'd0, imm_q}; end
          CmdBeq, CmdBne: begin
            wr_d = 1'b0;
            if ((rf_a == rf_b) == (cmd_q == CmdBeq)) begin
              jmp_d = 1'b1; npc_d = cpc_q + {se[29:0], 2'b00};
            end
          end
          CmdJ: begin wr_d = 1'b0; jmp_d = 1'b1; npc_d = tgt_q; end
          CmdJal: begin
            wreg_d = LinkReg; wval_d = cpc_q + LinkOffset; jmp_d = 1'b1; npc_d = tgt_q;
          end
          default: wr_d = 1'b0;
        endcase
      end
      StWait: begin
        wval_d = (cmd_q == CmdLw) ? dm_rdata : prod_q;
        st_d = StOut;
      end
      StDiv: if (div_rsp.done) begin
        wval_d = div_rsp.quotient;
        st_d = StOut;
      end
      StOut: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      rf_vld_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (rf_we) rf_vld_q[wreg_q] <= 1'b1;
      if (st_q == StOut) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i; rs_q <= src_reg_s_i; rt_q <= src_reg_t_i; rd_q <= dst_reg_d_i;
      sh_q <= shift_amount_i; imm_q <= immediate_i; tgt_q <= jump_target_i;
      cpc_q <= current_pc_i; ppc_q <= previous_pc_i;
      midx_q <= mem_word_index_i[MemAw-1:0]; mdata_q <= mem_word_data_i;
    end
    prod_q <= rf_a * rf_b;
    wr_q <= wr_d; jmp_q <= jmp_d; dz_q <= dz_d; wreg_q <= wreg_d;
    wval_q <= wval_d; npc_q <= npc_d;
  end

  assign out_valid_o = out_valid_q;
  assign reg_written_o = wr_q;
  assign written_reg_o = wr_q ? wreg_q : 5'd0;
  assign written_value_o = wr_q ? wval_q : 32'd0;
  assign pc_changed_o = jmp_q;
  assign next_pc_o = npc_q;
  assign next_previous_pc_o = jmp_q ? cpc_q : ppc_q;
  assign divide_by_zero_o = dz_q;

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> !accept) else $error("request taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(wval_q)))
    else $error("result changed while stalled");
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> (st_q == StDiv)) else $error("divider started outside divide");
  a_wb_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |=> !rf_we) else $error("double register write");
`endif
endmodule

FILE: tb/sv/tb_mips_subset_execute_stage.sv
// testbench for the mips subset execute stage: directed table, then random instruction mix
`timescale 1ns / 1ps
module tb_mips_subset_execute_stage;
  import mse_pkg::*;

  typedef struct {
    logic [4:0]  cmd;
    logic [4:0]  rs, rt, rd, sh;
    logic [15:0] imm;
    logic [31:0] target, cpc, ppc;
    logic [9:0]  midx;
    logic [31:0] mdata;
  } instr_t;

  typedef struct {
    logic        wr;
    logic [4:0]  wreg;
    logic [31:0] wval;
    logic        jump;
    logic [31:0] npc, nprev;
    logic        dz;
  } exec_result_t;

  typedef struct {
    instr_t       instr;
    bit           typed;
    exec_result_t res;
  } dir_row_t;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [4:0]  command_i, src_reg_s_i, src_reg_t_i, dst_reg_d_i, shift_amount_i;
  logic [15:0] immediate_i;
  logic [31:0] jump_target_i, current_pc_i, previous_pc_i, mem_word_data_i;
  logic [9:0]  mem_word_index_i;
  logic        reg_written_o, pc_changed_o, divide_by_zero_o;
  logic [4:0]  written_reg_o;
  logic [31:0] written_value_o, next_pc_o, next_previous_pc_o;

  mips_subset_execute_stage uut (.*);

  // architectural copy kept in step with the requests sent
  logic [31:0]  arch_regs [32];
  logic [31:0]  data_mem [MemWords];
  bit           mem_filled [MemWords];
  int           filled_idx [$];
  exec_result_t pending_results [$];
  dir_row_t     dir_rows [$];
  int           errors, n_checked, n_div, n_jump, n_lw, n_dz;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [31:0] sext(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] signed_quot(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic exec_result_t execute_instr(input instr_t x);
    exec_result_t r;
    logic [31:0] a, b, se;
    a = arch_regs[x.rs];
    b = arch_regs[x.rt];
    se = sext(x.imm);
    r = '{wr: 1'b0, wreg: '0, wval: '0, jump: 1'b0, npc: x.cpc, nprev: x.ppc, dz: 1'b0};
    case (x.cmd)
      CmdMove: begin r.wr = 1; r.wreg = x.rd; r.wval = a; end
      CmdAdd: begin r.wr = 1; r.wreg = x.rd; r.wval = a + b; end
      CmdSub, CmdSubu: begin r.wr = 1; r.wreg = x.rd; r.wval = a - b; end
      CmdMult, CmdMultu: begin r.wr = 1; r.wreg = x.rd; r.wval = a * b; end
      CmdDiv, CmdDivu: begin
        r.wr = 1; r.wreg = x.rd;
        if (b == 0) r.dz = 1;
        else r.wval = (x.cmd == CmdDiv) ? signed_quot(a, b) : a / b;
      end
      CmdAnd: begin r.wr = 1; r.wreg = x.rd; r.wval = a & b; end
      CmdNor: begin r.wr = 1; r.wreg = x.rd; r.wval = ~(a | b); end
      CmdOr: begin r.wr = 1; r.wreg = x.rd; r.wval = a | b; end
      CmdSlt: begin r.wr = 1; r.wreg = x.rd; r.wval = {31'd0, $signed(a) < $signed(b)}; end
      CmdSltu: begin r.wr = 1; r.wreg = x.rd; r.wval = {31'd0, a < b}; end
      CmdSll: begin r.wr = 1; r.wreg = x.rd; r.wval = b << x.sh; end
      CmdSrl: begin r.wr = 1; r.wreg = x.rd; r.wval = b >> x.sh; end
      CmdJr: begin r.jump = 1; r.npc = a; end
      CmdLi: begin r.wr = 1; r.wreg = x.rt; r.wval = {16'd0, x.imm}; end
      CmdLw: begin
        r.wr = 1; r.wreg = x.rt;
        r.wval = data_mem[(a + se) % MemWords];
      end
      CmdAddi, CmdAddiu: begin r.wr = 1; r.wreg = x.rt; r.wval = a + se; end
      CmdAndi: begin r.wr = 1; r.wreg = x.rt; r.wval = a & {16'd0, x.imm}; end
      CmdOri: begin r.wr = 1; r.wreg = x.rt; r.wval = a | {16'd0, x.imm}; end
      CmdBeq, CmdBne:
        if ((a == b) == (x.cmd == CmdBeq)) begin
          r.jump = 1; r.npc = x.cpc + (se << 2);
        end
      CmdJ: begin r.jump = 1; r.npc = x.target; end
      CmdJal: begin
        r.wr = 1; r.wreg = LinkReg; r.wval = x.cpc + LinkOffset;
        r.jump = 1; r.npc = x.target;
      end
      CmdMemload: begin
        data_mem[x.midx % MemWords] = x.mdata;
        if (!mem_filled[x.midx % MemWords]) filled_idx.push_back(x.midx % MemWords);
        mem_filled[x.midx % MemWords] = 1;
      end
      default: ;
    endcase
    if (r.wr) arch_regs[r.wreg] = r.wval;
    if (r.jump) r.nprev = x.cpc;
    return r;
  endfunction

  task automatic add_row(input logic [4:0] c, rs, rt, rd, sh, input logic [15:0] imm,
                         input logic [31:0] tgt, cpc, ppc, input logic [9:0] midx,
                         input logic [31:0] mdata, input bit typed, input logic [4:0] wreg,
                         input logic [31:0] val, input bit dz);
    dir_row_t row;
    row.instr = '{cmd: c, rs: rs, rt: rt, rd: rd, sh: sh, imm: imm, target: tgt, cpc: cpc,
                  ppc: ppc, midx: midx, mdata: mdata};
    row.typed = typed;
    row.res = '{wr: 1'b1, wreg: wreg, wval: val, jump: 1'b0, npc: cpc, nprev: ppc, dz: dz};
    dir_rows.push_back(row);
  endtask

  task automatic send_request(input instr_t x);
    command_i <= x.cmd;
    src_reg_s_i <= x.rs;
    src_reg_t_i <= x.rt;
    dst_reg_d_i <= x.rd;
    shift_amount_i <= x.sh;
    immediate_i <= x.imm;
    jump_target_i <= x.target;
    current_pc_i <= x.cpc;
    previous_pc_i <= x.ppc;
    mem_word_index_i <= x.midx;
    mem_word_data_i <= x.mdata;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic instr_t random_instr();
    instr_t x;
    int pick, w;
    x.cmd = 5'($urandom_range(0, 26));
    pick = $urandom_range(0, 99);
    if (pick < 10) x.cmd = CmdMemload;
    else if (pick < 12) x.cmd = 5'($urandom_range(28, 31));
    else if (pick < 17) x.cmd = CmdLi;
    x.rs = 5'($urandom); x.rt = 5'($urandom); x.rd = 5'($urandom);
    x.sh = 5'($urandom); x.imm = 16'($urandom);
    x.target = $urandom; x.cpc = $urandom; x.ppc = $urandom;
    x.midx = 10'($urandom); x.mdata = $urandom;
    // edge operands now and then
    if ($urandom_range(0, 7) == 0) x.imm = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h8000;
    // loads only reach words that were filled
    if (x.cmd == CmdLw) begin
      if (filled_idx.size() == 0) x.cmd = CmdSw;
      else begin
        w = filled_idx[$urandom_range(0, filled_idx.size() - 1)];
        x.imm[9:0] = 10'(w - arch_regs[x.rs]);
      end
    end
    return x;
  endfunction

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    exec_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: exp none got reg %0d val %h", $realtime,
                 written_reg_o, written_value_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (reg_written_o !== e.wr || written_reg_o !== e.wreg || written_value_o !== e.wval ||
            pc_changed_o !== e.jump || next_pc_o !== e.npc ||
            next_previous_pc_o !== e.nprev || divide_by_zero_o !== e.dz) begin
          $display("%0t mismatch: exp wr %b reg %0d val %h jmp %b pc %h prev %h dz %b",
                   $realtime, e.wr, e.wreg, e.wval, e.jump, e.npc, e.nprev, e.dz);
          $display("%0t           got wr %b reg %0d val %h jmp %b pc %h prev %h dz %b",
                   $realtime, reg_written_o, written_reg_o, written_value_o, pc_changed_o,
                   next_pc_o, next_previous_pc_o, divide_by_zero_o);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern, rotating through four modes
  int unsigned stall_cycle;
  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 1;
    case ((stall_cycle / 300) % 4)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 1) != 0);
      2: out_stall_i <= stall_cycle[2];
      default: out_stall_i <= ($urandom_range(0, 9) == 0);
    endcase
  end

  initial begin
    instr_t       x;
    exec_result_t e;
    int           burst_left;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    stall_cycle = 0;
    command_i = '0; src_reg_s_i = '0; src_reg_t_i = '0; dst_reg_d_i = '0;
    shift_amount_i = '0; immediate_i = '0; jump_target_i = '0; current_pc_i = '0;
    previous_pc_i = '0; mem_word_index_i = '0; mem_word_data_i = '0;
    errors = 0; n_checked = 0; n_div = 0; n_jump = 0; n_lw = 0; n_dz = 0;
    foreach (arch_regs[i]) arch_regs[i] = '0;
    foreach (data_mem[i]) begin data_mem[i] = '0; mem_filled[i] = 0; end

    // register file reads zero after reset
    add_row(CmdMove, 5'd9, 0, 5'd2, 0, 16'h0, 0, 32'hFFFF_FFFC, 0, 0, 0, 1, 5'd2, 32'h0, 0);
    add_row(CmdLi, 0, 5'd1, 0, 0, 16'hFFFF, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0,
            1, 5'd1, 32'h0000_FFFF, 0);
    add_row(CmdAddi, 5'd0, 5'd4, 0, 0, 16'h8000, 0, 32'h0, 32'h0, 0, 0,
            1, 5'd4, 32'hFFFF_8000, 0);
    add_row(CmdLi, 0, 5'd6, 0, 0, 16'h8000, 0, 32'h100, 32'hFC, 0, 0, 1, 5'd6, 32'h8000, 0);
    add_row(CmdSll, 0, 5'd6, 5'd6, 5'd16, 0, 0, 32'h104, 32'h100, 0, 0,
            1, 5'd6, 32'h8000_0000, 0);
    add_row(CmdAddiu, 5'd0, 5'd7, 0, 0, 16'hFFFF, 0, 32'h108, 32'h104, 0, 0,
            1, 5'd7, 32'hFFFF_FFFF, 0);
    // most negative over minus one wraps
    add_row(CmdDiv, 5'd6, 5'd7, 5'd8, 0, 0, 0, 32'h10C, 32'h108, 0, 0, 0, 0, 0, 0);
    add_row(CmdDiv, 5'd7, 5'd0, 5'd9, 0, 0, 0, 32'h110, 32'h10C, 0, 0, 1, 5'd9, 32'h0, 1);
    add_row(CmdDivu, 5'd7, 5'd3, 5'd10, 0, 0, 0, 32'h114, 32'h110, 0, 0,
            1, 5'd10, 32'h0, 1);
    add_row(CmdDivu, 5'd7, 5'd1, 5'd11, 0, 0, 0, 32'h118, 32'h114, 0, 0, 0, 0, 0, 0);
    add_row(CmdAdd, 5'd7, 5'd6, 5'd12, 0, 0, 0, 32'h11C, 32'h118, 0, 0, 0, 0, 0, 0);
    add_row(CmdSub, 5'd6, 5'd7, 5'd13, 0, 0, 0, 32'h120, 32'h11C, 0, 0, 0, 0, 0, 0);
    add_row(CmdSubu, 5'd0, 5'd7, 5'd13, 0, 0, 0, 32'h124, 32'h120, 0, 0, 0, 0, 0, 0);
    add_row(CmdMult, 5'd7, 5'd6, 5'd14, 0, 0, 0, 32'h128, 32'h124, 0, 0, 0, 0, 0, 0);
    add_row(CmdMultu, 5'd7, 5'd7, 5'd15, 0, 0, 0, 32'h12C, 32'h128, 0, 0, 0, 0, 0, 0);
    add_row(CmdAnd, 5'd7, 5'd4, 5'd16, 0, 0, 0, 32'h130, 32'h12C, 0, 0, 0, 0, 0, 0);
    add_row(CmdNor, 5'd6, 5'd1, 5'd17, 0, 0, 0, 32'h134, 32'h130, 0, 0, 0, 0, 0, 0);
    add_row(CmdOr, 5'd6, 5'd1, 5'd18, 0, 0, 0, 32'h138, 32'h134, 0, 0, 0, 0, 0, 0);
    add_row(CmdSlt, 5'd6, 5'd1, 5'd19, 0, 0, 0, 32'h13C, 32'h138, 0, 0, 1, 5'd19, 32'h1, 0);
    add_row(CmdSltu, 5'd6, 5'd1, 5'd20, 0, 0, 0, 32'h140, 32'h13C, 0, 0, 1, 5'd20, 32'h0, 0);
    // logical right shift of a negative word
    add_row(CmdSrl, 0, 5'd7, 5'd21, 5'd31, 0, 0, 32'h144, 32'h140, 0, 0,
            1, 5'd21, 32'h1, 0);
    add_row(CmdMemload, 0, 0, 0, 0, 0, 0, 32'h148, 32'h144, 10'd1023, 32'hFFFF_FFFF,
            0, 0, 0, 0);
    add_row(CmdLw, 5'd0, 5'd22, 0, 0, 16'hFFFF, 0, 32'h14C, 32'h148, 0, 0,
            1, 5'd22, 32'hFFFF_FFFF, 0);
    add_row(CmdAndi, 5'd7, 5'd23, 0, 0, 16'h8001, 0, 32'h150, 32'h14C, 0, 0,
            1, 5'd23, 32'h8001, 0);
    add_row(CmdOri, 5'd6, 5'd24, 0, 0, 16'hFFFF, 0, 32'h154, 32'h150, 0, 0,
            1, 5'd24, 32'h8000_FFFF, 0);
    add_row(CmdLi, 0, 5'd0, 0, 0, 16'h1234, 0, 32'h158, 32'h154, 0, 0, 1, 5'd0, 32'h1234, 0);
    add_row(CmdBeq, 5'd2, 5'd3, 0, 0, 16'h8000, 0, 32'h15C, 32'h158, 0, 0, 0, 0, 0, 0);
    add_row(CmdBne, 5'd2, 5'd3, 0, 0, 16'h7FFF, 0, 32'h160, 32'h15C, 0, 0, 0, 0, 0, 0);
    add_row(CmdBne, 5'd6, 5'd7, 0, 0, 16'h7FFF, 0, 32'h164, 32'h160, 0, 0, 0, 0, 0, 0);
    add_row(CmdJ, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h168, 32'h164, 0, 0, 0, 0, 0, 0);
    add_row(CmdJal, 0, 0, 0, 0, 0, 32'h0, 32'hFFFF_FFFC, 32'h168, 0, 0, 0, 0, 0, 0);
    add_row(CmdJr, 5'd6, 0, 0, 0, 0, 0, 32'h170, 32'h16C, 0, 0, 0, 0, 0, 0);
    add_row(CmdSw, 5'd6, 5'd7, 0, 0, 0, 0, 32'h174, 32'h170, 0, 0, 0, 0, 0, 0);
    add_row(5'd31, 5'd6, 5'd7, 5'd1, 0, 0, 0, 32'h178, 32'h174, 0, 0, 0, 0, 0, 0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_rows[i]) begin
      e = execute_instr(dir_rows[i].instr);
      pending_results.push_back(dir_rows[i].typed ? dir_rows[i].res : e);
      send_request(dir_rows[i].instr);
    end

    burst_left = 0;
    for (int n = 0; n < 1900; n++) begin
      if (n == 950) begin
        // hold off until every outstanding request has returned
        in_valid_i <= 1'b0;
        wait_drained();
      end
      x = random_instr();
      if (x.cmd == CmdDiv || x.cmd == CmdDivu) n_div++;
      if (x.cmd == CmdLw) n_lw++;
      e = execute_instr(x);
      n_jump += e.jump;
      n_dz += e.dz;
      pending_results.push_back(e);
      send_request(x);
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ((n / 200) % 3 != 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
      end else burst_left--;
    end
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (60) @(posedge clk_i);

    $display("checked %0d results: %0d divides (%0d by zero), %0d loads, %0d pc changes",
             n_checked, n_div, n_dz, n_lw, n_jump);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/core/mse_pkg.sv
rtl/core/mse_ram.sv
rtl/core/mse_div.sv
rtl/core/mips_subset_execute_stage.sv
tb/sv/tb_mips_subset_execute_stage.sv
